### rtl/cuq_pkg.sv
package cuq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [1:0] KIND_RESET   = 2'd0;
  localparam logic [1:0] KIND_REPLACE = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;

  localparam logic [1:0] OUT_APPENDED = 2'd0;
  localparam logic [1:0] OUT_REPLACED = 2'd1;
  localparam logic [1:0] OUT_EVICTED  = 2'd2;
  localparam logic [1:0] OUT_NO_PUSH  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  update_kind;
    logic [31:0] series_key;
    logic        single_bar;
    logic [47:0] bar_open_time;
    logic [31:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [1:0]  out_kind;
    logic [31:0] out_key;
    logic        out_single_bar;
    logic [47:0] out_open_time;
    logic [31:0] out_payload;
    logic        last_of_run;
    logic [4:0]  fill_level;
    logic [31:0] coalesced_count;
    logic [31:0] dropped_count;
    logic [4:0]  peak_fill;
    logic [1:0]  push_outcome;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_CAP,
    ST_APPEND,
    ST_STATUS,
    ST_POP,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic remove_key;
    logic replace;
    logic evict;
    logic append;
    logic emit_status;
    logic pop;
    logic drain_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic key_hit;
    logic rep_hit;
    logic full;
    logic occ_zero;
    logic out_free;
    logic drain_last;
  } dp_stat_t;

endpackage

### rtl/cuq_ctrl.sv
module cuq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cuq_pkg::in_item_t in_data,
  input  cuq_pkg::dp_stat_t stat,
  output cuq_pkg::ctl_cmd_t cmd,
  output logic              busy
);
  import cuq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_data.command)
            CMD_PUSH: begin
              if (in_data.update_kind == KIND_RESET) begin
                state_nxt = ST_SCAN;
              end else if (in_data.update_kind == KIND_REPLACE && in_data.single_bar) begin
                state_nxt = ST_REPL;
              end else begin
                state_nxt = ST_CAP;
              end
            end
            CMD_POP:   state_nxt = ST_POP;
            CMD_DRAIN: state_nxt = stat.occ_zero ? ST_STATUS : ST_DRAIN;
            default:   state_nxt = ST_STATUS;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.key_hit) begin
          cmd.remove_key = 1'b1;
        end else begin
          state_nxt = ST_CAP;
        end
      end
      ST_REPL: begin
        if (stat.rep_hit) begin
          cmd.replace = 1'b1;
          state_nxt = ST_STATUS;
        end else begin
          state_nxt = ST_CAP;
        end
      end
      ST_CAP: begin
        if (stat.full) begin
          cmd.evict = 1'b1;
          state_nxt = ST_APPEND;
        end else begin
          cmd.append = 1'b1;
          state_nxt = ST_STATUS;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt = ST_STATUS;
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        if (stat.out_free) begin
          if (stat.occ_zero) cmd.emit_status = 1'b1;
          else cmd.pop = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain_emit = 1'b1;
          if (stat.drain_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/cuq_dp.sv
module cuq_dp #(
  parameter int QUEUE_DEPTH = cuq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = cuq_pkg::KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cuq_pkg::in_item_t  in_data,
  input  logic               cfg_valid,
  input  logic [4:0]         cfg_data,
  input  cuq_pkg::ctl_cmd_t  cmd,
  output cuq_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output cuq_pkg::out_item_t out_data
);
  import cuq_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = (OCC_W > 5) ? OCC_W : 5;

  typedef struct packed {
    logic [1:0]          kind;
    logic [KEY_BITS-1:0] key;
    logic                single;
    logic [47:0]         otime;
    logic [31:0]         payload;
  } slot_t;

  slot_t             slot_r [QUEUE_DEPTH];
  slot_t             cur_r;
  logic [1:0]        cmd_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  peak_r;
  logic [31:0]       coal_r;
  logic [31:0]       drop_r;
  logic [4:0]        cap_r;
  logic [1:0]        outcome_r;
  logic [IW-1:0]     drain_idx_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [QUEUE_DEPTH-1:0] key_m, rep_m, kind_m;
  logic [IW-1:0]          key_idx, rep_idx, victim_idx, rm_idx;
  logic [CW-1:0]          eff_cap;
  logic [95:0]            key_in_x;
  logic [95:0]            key_out_x;
  slot_t                  new_slot;
  slot_t                  out_slot;
  logic                   do_remove;
  logic                   out_free;

  // The incoming key is compared on its low KEY_BITS bits.
  assign key_in_x = {64'b0, in_data.series_key};

  always_comb begin
    key_m = '0;
    rep_m = '0;
    kind_m = '0;
    key_idx = '0;
    rep_idx = '0;
    victim_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (OCC_W'(i) < occ_r) begin
        key_m[i]  = (slot_r[i].key == cur_r.key);
        kind_m[i] = (slot_r[i].kind == KIND_REPLACE);
        rep_m[i]  = kind_m[i] && key_m[i] && slot_r[i].single &&
                    (slot_r[i].otime == cur_r.otime);
      end
    end
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (key_m[i])  key_idx = IW'(i);
      if (rep_m[i])  rep_idx = IW'(i);
      if (kind_m[i]) victim_idx = IW'(i);
    end
  end

  always_comb begin
    if (cap_r == 5'd0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_r) > CW'(QUEUE_DEPTH)) begin
      eff_cap = CW'(QUEUE_DEPTH);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  assign stat.key_hit    = |key_m;
  assign stat.rep_hit    = |rep_m;
  assign stat.full       = (CW'(occ_r) >= eff_cap);
  assign stat.occ_zero   = (occ_r == '0);
  assign stat.out_free   = out_free;
  assign stat.drain_last = (OCC_W'(drain_idx_r) == occ_r - OCC_W'(1));

  assign do_remove = cmd.remove_key || cmd.evict || cmd.pop;

  always_comb begin
    if (cmd.remove_key) rm_idx = key_idx;
    else if (cmd.evict) rm_idx = victim_idx;
    else rm_idx = '0;
  end

  always_comb begin
    new_slot.kind    = (in_data.update_kind == 2'd3) ? KIND_OTHER : in_data.update_kind;
    new_slot.key     = key_in_x[KEY_BITS-1:0];
    new_slot.single  = in_data.single_bar;
    new_slot.otime   = in_data.bar_open_time;
    new_slot.payload = in_data.payload_handle;
  end

  always_comb begin
    if (cmd.drain_emit) out_slot = slot_r[drain_idx_r];
    else out_slot = slot_r[0];
  end

  assign key_out_x = {{(96 - KEY_BITS){1'b0}}, out_slot.key};

  // Slot store: removal shifts every later entry down by one place.
  always_ff @(posedge clk) begin
    if (cmd.load) cur_r <= new_slot;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_remove && IW'(i) >= rm_idx && i < QUEUE_DEPTH - 1) begin
        slot_r[i] <= slot_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
    if (cmd.replace) slot_r[rep_idx] <= cur_r;
    if (cmd.append) slot_r[occ_r[IW-1:0]] <= cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      peak_r      <= '0;
      coal_r      <= '0;
      drop_r      <= '0;
      cap_r       <= CAP_RESET;
      outcome_r   <= OUT_NO_PUSH;
      drain_idx_r <= '0;
      cmd_r       <= CMD_PUSH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cap_r <= cfg_data;
      if (cmd.load) begin
        cmd_r       <= in_data.command;
        outcome_r   <= (in_data.command == CMD_PUSH) ? OUT_APPENDED : OUT_NO_PUSH;
        drain_idx_r <= '0;
      end
      if (cmd.remove_key || cmd.replace) begin
        if (coal_r != 32'hFFFF_FFFF) coal_r <= coal_r + 32'd1;
      end
      if (cmd.replace) outcome_r <= OUT_REPLACED;
      if (cmd.evict) begin
        if (drop_r != 32'hFFFF_FFFF) drop_r <= drop_r + 32'd1;
        outcome_r <= OUT_EVICTED;
      end
      if (do_remove) occ_r <= occ_r - OCC_W'(1);
      if (cmd.append) begin
        occ_r <= occ_r + OCC_W'(1);
        if (occ_r + OCC_W'(1) > peak_r) peak_r <= occ_r + OCC_W'(1);
      end
      if (cmd.drain_emit) begin
        drain_idx_r <= drain_idx_r + IW'(1);
        if (stat.drain_last) occ_r <= '0;
      end
      if (cmd.emit_status || cmd.pop || cmd.drain_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status || cmd.pop || cmd.drain_emit) begin
      out_r.entry_valid     <= cmd.pop || cmd.drain_emit;
      out_r.out_kind        <= (cmd.emit_status) ? 2'd0 : out_slot.kind;
      out_r.out_key         <= (cmd.emit_status) ? 32'd0 : key_out_x[31:0];
      out_r.out_single_bar  <= (cmd.emit_status) ? 1'b0 : out_slot.single;
      out_r.out_open_time   <= (cmd.emit_status) ? 48'd0 : out_slot.otime;
      out_r.out_payload     <= (cmd.emit_status) ? 32'd0 : out_slot.payload;
      out_r.last_of_run     <= !cmd.drain_emit || stat.drain_last;
      out_r.coalesced_count <= coal_r;
      out_r.dropped_count   <= drop_r;
      out_r.peak_fill       <= 5'(peak_r);
      out_r.push_outcome    <= (cmd_r == CMD_PUSH) ? outcome_r : OUT_NO_PUSH;
      if (cmd.drain_emit) out_r.fill_level <= 5'd0;
      else if (cmd.pop) out_r.fill_level <= 5'(occ_r - OCC_W'(1));
      else out_r.fill_level <= 5'(occ_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/coalescing_update_queue_core.sv
// Plain push: capacity check, append, status result. Replace in place: overwrite the match,
// status. A reset push first removes each entry with its key, an unmatched single-bar replace
// push first tries the replace; both then run as a plain push, evicting first when full. Pop
// emits the head, drain every entry; a stalled output holds them. Items are taken one at a
// time; the result register lets the next word be accepted while the last result waits.
// Synchronous active-low reset clears counters, fill level and capacity (16), not the slots.
module coalescing_update_queue_core #(
  parameter int QUEUE_DEPTH = cuq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = cuq_pkg::KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cuq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cuq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);
  import cuq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  cuq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  cuq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Every accepted word makes the sequencer busy in the cycle after it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A result without an entry is always the last one of its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.entry_valid) |-> out_data.last_of_run)
    else $error("status result not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fill_level <= out_data.peak_fill))
    else $error("fill level above peak");

endmodule
